FILE: src/rpc_pkg.sv
// shared constants and types for the raster to page column converter
package rpc_pkg;

    localparam int DEF_WIDTH_PIXELS  = 128;
    localparam int DEF_HEIGHT_PIXELS = 64;

    localparam int MEM_DEPTH = 1024;
    localparam int MEM_AW    = 10;

    // op codes of an input item
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    // configuration register indexes
    localparam logic CFG_FB_MSB_LEFT     = 1'b0;
    localparam logic CFG_DISPLAY_MSB_TOP = 1'b1;

    // panel position commands
    localparam logic [7:0] CMD_PAGE_BASE    = 8'hB0;
    localparam logic [7:0] CMD_COL_LOW_MASK = 8'h0F;
    localparam logic [7:0] CMD_COL_HIGH     = 8'h10;

    // emit slots: three commands then eight data bytes
    localparam logic [3:0] SLOT_PAGE     = 4'd0;
    localparam logic [3:0] SLOT_COL_LOW  = 4'd1;
    localparam logic [3:0] SLOT_COL_HIGH = 4'd2;
    localparam logic [3:0] SLOT_DATA0    = 4'd3;
    localparam logic [3:0] SLOT_LAST     = 4'd10;

    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_READ  = 4'b0100,
        ST_EMIT  = 4'b1000
    } t_state;

    typedef logic [7:0] t_col_bytes [8];

endpackage

FILE: src/rpc_if.sv
// handshake channels: input items, result items and configuration writes
interface rpc_in_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [9:0] byte_address;
    logic [7:0] write_byte;
    logic [2:0] page;
    logic [3:0] column_group;

    modport source (output valid, op, byte_address, write_byte, page, column_group,
                    input ready);
    modport sink   (input valid, op, byte_address, write_byte, page, column_group,
                    output ready);
endinterface

interface rpc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       is_command;
    logic       last;

    modport source (output valid, out_byte, is_command, last, input ready);
    modport sink   (input valid, out_byte, is_command, last, output ready);
endinterface

interface rpc_cfg_if;
    logic valid;
    logic ready;
    logic index;
    logic data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: src/raster_to_page_column_converter_top.sv
// raster to page column converter: frame memory, block reader and 8x8 transpose
// reads: after a read item is accepted the eight rows of its block are read, one a
//   cycle, and transposed; the next item is taken once the last of the results (11
//   for column group 0, 8 for others) is in the output register, which stalls delay
// writes: a write item is taken in the idle state through the single write port
// reset: synchronous active low; afterwards a clearing pass over every address zeroes
//   the frame memory, during which input items are held off (config is taken)
module raster_to_page_column_converter_top
    import rpc_pkg::*;
#(
    parameter int WIDTH_PIXELS  = DEF_WIDTH_PIXELS,
    parameter int HEIGHT_PIXELS = DEF_HEIGHT_PIXELS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    rpc_in_if.sink        i_in,
    rpc_out_if.source     o_out,
    rpc_cfg_if.sink       i_cfg
);

    // bytes per framebuffer row
    localparam int ROW_BYTES = WIDTH_PIXELS / 8;

    // state and control
    t_state r_state, n_state;
    logic [MEM_AW-1:0] r_clr_addr;
    logic [3:0] r_rd_cnt;           // read issue counter, 8 means all issued
    logic       r_rd_vld;           // read data arriving this cycle
    logic [2:0] r_rd_row;           // row within the page of the arriving data
    logic [3:0] r_slot;             // next emit slot

    // latched request
    logic [2:0] r_page;
    logic [3:0] r_group;
    logic       r_on_panel;

    // configuration
    logic r_fb_msb_left;
    logic r_display_msb_top;

    // transposed column bytes
    t_col_bytes r_col, n_col;

    // output register
    logic       r_out_vld;
    logic [7:0] r_out_byte;
    logic       r_out_cmd;
    logic       r_out_last;

    // frame memory, one write and one registered read port
    logic [7:0]        mem [MEM_DEPTH];
    logic [7:0]        r_rd_data;
    logic              mem_we;
    logic [MEM_AW-1:0] mem_waddr;
    logic [7:0]        mem_wdata;
    logic [MEM_AW-1:0] rd_addr;

    logic in_acc;
    logic out_load;
    logic on_panel_in;
    logic [5:0]  rd_row;
    logic [15:0] rd_off;
    logic [6:0]  column;
    logic [3:0]  data_idx;
    logic [7:0]  slot_byte;

    assign i_in.ready  = (r_state == ST_IDLE);
    assign i_cfg.ready = 1'b1;
    assign in_acc      = i_in.valid && i_in.ready;

    // block lies on the panel if its page and column group fit
    assign on_panel_in = (7'({i_in.page, 3'b000}) < 7'(HEIGHT_PIXELS)) &&
                         (8'({i_in.column_group, 3'b000}) + 8'd8 <= 8'(WIDTH_PIXELS));

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fb_msb_left     <= 1'b0;
            r_display_msb_top <= 1'b0;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                CFG_FB_MSB_LEFT:     r_fb_msb_left     <= i_cfg.data;
                CFG_DISPLAY_MSB_TOP: r_display_msb_top <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // write port: clearing pass or a framebuffer write item
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_clr_addr;
        mem_wdata = 8'h00;
        if (r_state == ST_CLEAR) begin
            mem_we = 1'b1;
        end else if (in_acc && i_in.op == OP_WRITE) begin
            mem_we    = 1'b1;
            mem_waddr = i_in.byte_address;
            mem_wdata = i_in.write_byte;
        end
    end

    // read address: row of the page times bytes per row plus the column group
    assign rd_row  = {r_page, r_rd_cnt[2:0]};
    assign rd_off  = 16'(rd_row) * 16'(ROW_BYTES) + 16'(r_group);
    assign rd_addr = rd_off[MEM_AW-1:0];

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= mem[rd_addr];
    end

    // 8x8 transpose: each arriving row sets one bit in every column byte
    always_comb begin
        logic [2:0] dbit;
        logic [2:0] sbit;
        n_col = r_col;
        sbit  = 3'd0;
        dbit  = r_display_msb_top ? ~r_rd_row : r_rd_row;
        if (r_state == ST_IDLE) begin
            for (int c = 0; c < 8; c++) begin
                n_col[c] = 8'h00;
            end
        end else if (r_rd_vld && r_on_panel) begin
            for (int c = 0; c < 8; c++) begin
                sbit = r_fb_msb_left ? ~3'(c) : 3'(c);
                n_col[c][dbit] = r_rd_data[sbit];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_col <= n_col;
    end

    // byte for the current emit slot
    assign column   = {r_group, 3'b000};
    assign data_idx = r_slot - SLOT_DATA0;

    always_comb begin
        case (r_slot)
            SLOT_PAGE:     slot_byte = CMD_PAGE_BASE + 8'(r_page);
            SLOT_COL_LOW:  slot_byte = 8'(column) & CMD_COL_LOW_MASK;
            SLOT_COL_HIGH: slot_byte = CMD_COL_HIGH | 8'(column >> 4);
            default:       slot_byte = r_col[data_idx[2:0]];
        endcase
    end

    assign out_load = (r_state == ST_EMIT) && (!r_out_vld || o_out.ready);

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr_addr == MEM_AW'(MEM_DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_acc && i_in.op == OP_READ) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                if (r_rd_cnt == 4'd8) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_load && r_slot == SLOT_LAST) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
            r_rd_cnt   <= '0;
            r_rd_vld   <= 1'b0;
            r_slot     <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            r_rd_vld <= (r_state == ST_READ) && (r_rd_cnt < 4'd8);
            r_rd_row <= r_rd_cnt[2:0];
            if (r_state == ST_READ && r_rd_cnt < 4'd8) begin
                r_rd_cnt <= r_rd_cnt + 1'b1;
            end else if (r_state == ST_IDLE) begin
                r_rd_cnt <= '0;
            end
            if (in_acc && i_in.op == OP_READ) begin
                // commands only lead the run of column group 0
                r_slot <= (i_in.column_group == 4'd0) ? SLOT_PAGE : SLOT_DATA0;
            end else if (out_load) begin
                r_slot <= r_slot + 1'b1;
            end
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // request and output payload
    always_ff @(posedge i_clk) begin
        if (in_acc && i_in.op == OP_READ) begin
            r_page     <= i_in.page;
            r_group    <= i_in.column_group;
            r_on_panel <= on_panel_in;
        end
        if (out_load) begin
            r_out_byte <= slot_byte;
            r_out_cmd  <= (r_slot < SLOT_DATA0);
            r_out_last <= (r_slot == SLOT_LAST);
        end
    end

    assign o_out.valid      = r_out_vld;
    assign o_out.out_byte   = r_out_byte;
    assign o_out.is_command = r_out_cmd;
    assign o_out.last       = r_out_last;

endmodule

FILE: src/rpc_checker.sv
// port checker for the raster to page column converter, bound to the top level
module rpc_checker
    import rpc_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_in_op,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_byte,
    input logic       i_out_is_command,
    input logic       i_out_last
);

    // the closing byte of a run is always data
    a_last_is_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_last) |-> !i_out_is_command)
        else $error("last item flagged as command");

    // command bytes are page select or column address only
    a_cmd_codes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_is_command) |->
            ((i_out_byte & 8'hF8) == CMD_PAGE_BASE || i_out_byte == 8'h00 ||
             i_out_byte == CMD_COL_HIGH))
        else $error("unexpected command byte");

    // a block request keeps the input side busy while it runs
    a_busy_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && i_in_op == OP_READ) |=> !i_in_ready)
        else $error("input taken during a block request");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_byte) && $stable(i_out_is_command) &&
             $stable(i_out_last)))
        else $error("stalled result changed");

endmodule

bind raster_to_page_column_converter_top rpc_checker u_rpc_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in.valid),
    .i_in_ready       (i_in.ready),
    .i_in_op          (i_in.op),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_out_byte       (o_out.out_byte),
    .i_out_is_command (o_out.is_command),
    .i_out_last       (o_out.last)
);

FILE: tb/raster_to_page_column_converter_top_tb.sv
// testbench for the raster to page column converter: directed rows, then random traffic
module raster_to_page_column_converter_top_tb;
    import rpc_pkg::*;

    localparam int WIDTH_PIXELS       = DEF_WIDTH_PIXELS;
    localparam int HEIGHT_PIXELS      = DEF_HEIGHT_PIXELS;
    // settle time after the results have drained, a safe margin for the block to go idle
    localparam int SETTLE_CYCLES      = 30;
    localparam int RANDOM_PER_SETTING = 50;
    localparam int MAX_PRINTED        = 20;
    localparam int NUM_DIRECTED       = 23;

    // one byte sent towards the panel
    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_command;
        logic       last;
    } t_panel_byte;

    // one input item; typed rows carry their expected command and data bytes
    typedef struct packed {
        logic       op;
        logic [9:0] addr;
        logic [7:0] wbyte;
        logic [2:0] page;
        logic [3:0] grp;
        logic       typed;
        logic [7:0] typed_cmd;
        logic [7:0] typed_data;
    } t_stim;

    // receiver behaviour: always ready, coin toss, or mostly stalled
    typedef enum int {
        SINK_FREE,
        SINK_RANDOM,
        SINK_CHOKED
    } t_sink_mode;

    // directed rows: empty frame, the corners, full bytes, single bits and ignored fields
    localparam t_stim DIRECTED [NUM_DIRECTED] = '{
        // freshly cleared frame reads as zeros, commands only for group 0
        '{OP_READ,  10'd0,    8'h00, 3'd0, 4'd0,  1'b1, CMD_PAGE_BASE,         8'h00},
        '{OP_READ,  10'd1023, 8'hFF, 3'd7, 4'd15, 1'b1, CMD_PAGE_BASE,         8'h00},
        '{OP_READ,  10'd512,  8'hA5, 3'd7, 4'd0,  1'b1, CMD_PAGE_BASE + 8'd7,  8'h00},
        // fill page 0 group 0 with ones; page and group fields are ignored on a write
        '{OP_WRITE, 10'd0,    8'hFF, 3'd7, 4'd15, 1'b0, 8'h00, 8'h00},
        '{OP_WRITE, 10'd16,   8'hFF, 3'd5, 4'd10, 1'b0, 8'h00, 8'h00},
        '{OP_WRITE, 10'd32,   8'hFF, 3'd2, 4'd5,  1'b0, 8'h00, 8'h00},
        '{OP_WRITE, 10'd48,   8'hFF, 3'd0, 4'd0,  1'b0, 8'h00, 8'h00},
        '{OP_WRITE, 10'd64,   8'hFF, 3'd1, 4'd1,  1'b0, 8'h00, 8'h00},
        '{OP_WRITE, 10'd80,   8'hFF, 3'd6, 4'd9,  1'b0, 8'h00, 8'h00},
        '{OP_WRITE, 10'd96,   8'hFF, 3'd3, 4'd6,  1'b0, 8'h00, 8'h00},
        '{OP_WRITE, 10'd112,  8'hFF, 3'd4, 4'd3,  1'b0, 8'h00, 8'h00},
        // all ones survive any orientation; address and byte ignored on a read
        '{OP_READ,  10'd1023, 8'hFF, 3'd0, 4'd0,  1'b1, CMD_PAGE_BASE,         8'hFF},
        // last byte of the memory and its neighbour above, single bits at both ends
        '{OP_WRITE, 10'd1023, 8'h80, 3'd0, 4'd0,  1'b0, 8'h00, 8'h00},
        '{OP_WRITE, 10'd1007, 8'h01, 3'd7, 4'd15, 1'b0, 8'h00, 8'h00},
        '{OP_READ,  10'd0,    8'h00, 3'd7, 4'd15, 1'b0, 8'h00, 8'h00},
        '{OP_WRITE, 10'd0,    8'h01, 3'd0, 4'd0,  1'b0, 8'h00, 8'h00},
        '{OP_WRITE, 10'd16,   8'h80, 3'd0, 4'd0,  1'b0, 8'h00, 8'h00},
        '{OP_READ,  10'd0,    8'h00, 3'd0, 4'd0,  1'b0, 8'h00, 8'h00},
        '{OP_WRITE, 10'd527,  8'h5A, 3'd2, 4'd2,  1'b0, 8'h00, 8'h00},
        '{OP_READ,  10'd527,  8'h5A, 3'd4, 4'd15, 1'b0, 8'h00, 8'h00},
        '{OP_WRITE, 10'd1022, 8'hFF, 3'd0, 4'd0,  1'b0, 8'h00, 8'h00},
        '{OP_READ,  10'd1022, 8'h00, 3'd7, 4'd14, 1'b0, 8'h00, 8'h00},
        '{OP_READ,  10'd0,    8'h00, 3'd0, 4'd1,  1'b0, 8'h00, 8'h00}
    };

    // settings walked in the random part, as {fb_msb_left, display_msb_top}
    localparam logic [1:0] RANDOM_SETTINGS [4] = '{2'b10, 2'b01, 2'b11, 2'b00};

    logic i_clk;
    logic i_rst_n;

    rpc_in_if  in_ch ();
    rpc_out_if out_ch ();
    rpc_cfg_if cfg_ch ();

    raster_to_page_column_converter_top #(
        .WIDTH_PIXELS  (WIDTH_PIXELS),
        .HEIGHT_PIXELS (HEIGHT_PIXELS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    // own copy of the framebuffer and of the two orientation bits
    logic [7:0]  frame_copy [MEM_DEPTH];
    logic        copy_fb_msb_left;
    logic        copy_display_msb_top;

    // bytes the panel should still receive, oldest first
    t_panel_byte panel_bytes_due [$];

    int          mismatch_count = 0;
    int          burst_left     = 1;
    t_sink_mode  sink_mode      = SINK_FREE;
    int          sink_mode_left = 0;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // generous limit: clearing pass plus every read fully stalled, many times over
    initial begin
        #1_600_000;
        $display("Simulation FAILED");
        $finish;
    end

    task automatic report_mismatch(input string what);
        if (mismatch_count < MAX_PRINTED)
            $display("%0t mismatch: %s", $time, what);
        mismatch_count++;
    endtask

    // 8x8 transpose of one page block, with the position commands for group 0
    task automatic transpose_block(input logic [2:0] page, input logic [3:0] grp);
        logic [7:0] col_bytes [8];
        logic [7:0] src;
        for (int c = 0; c < 8; c++)
            col_bytes[c] = 8'h00;
        // off-panel blocks read as zeros
        if (int'(page) * 8 < HEIGHT_PIXELS && int'(grp) * 8 + 8 <= WIDTH_PIXELS) begin
            for (int r = 0; r < 8; r++) begin
                // row page*8+r, byte grp of that row
                src = frame_copy[{page, 3'(r), grp}];
                for (int c = 0; c < 8; c++)
                    col_bytes[c][copy_display_msb_top ? 7 - r : r] =
                        src[copy_fb_msb_left ? 7 - c : c];
            end
        end
        if (grp == 4'd0) begin
            // column 0: low nibble and high nibble are both zero
            panel_bytes_due.push_back('{CMD_PAGE_BASE + 8'(page), 1'b1, 1'b0});
            panel_bytes_due.push_back('{CMD_COL_LOW_MASK & 8'h00, 1'b1, 1'b0});
            panel_bytes_due.push_back('{CMD_COL_HIGH | 8'h00, 1'b1, 1'b0});
        end
        for (int c = 0; c < 8; c++)
            panel_bytes_due.push_back('{col_bytes[c], 1'b0, c == 7});
    endtask

    // drive one item, wait for its handshake, book its effect, then pace the sender
    task automatic send_item(input t_stim s);
        int gap;
        in_ch.valid        <= 1'b1;
        in_ch.op           <= s.op;
        in_ch.byte_address <= s.addr;
        in_ch.write_byte   <= s.wbyte;
        in_ch.page         <= s.page;
        in_ch.column_group <= s.grp;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);

        if (s.op == OP_WRITE) begin
            frame_copy[s.addr] = s.wbyte;
        end else if (s.typed) begin
            // typed rows: uniform data bytes, the page command as written in the row
            if (s.grp == 4'd0) begin
                panel_bytes_due.push_back('{s.typed_cmd, 1'b1, 1'b0});
                panel_bytes_due.push_back('{8'h00, 1'b1, 1'b0});
                panel_bytes_due.push_back('{CMD_COL_HIGH, 1'b1, 1'b0});
            end
            for (int c = 0; c < 8; c++)
                panel_bytes_due.push_back('{s.typed_data, 1'b0, c == 7});
        end else begin
            transpose_block(s.page, s.grp);
        end

        // bursts of random length; a zero gap keeps valid high into the next burst
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // hold the sender until every byte has come out and the block has settled
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (panel_bytes_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        burst_left = 1;
    endtask

    // both registers written back to back, valid held between them
    task automatic write_settings(input logic msb_left, input logic msb_top);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= CFG_FB_MSB_LEFT;
        cfg_ch.data  <= msb_left;
        do @(posedge i_clk); while (cfg_ch.ready !== 1'b1);
        copy_fb_msb_left = msb_left;
        cfg_ch.index <= CFG_DISPLAY_MSB_TOP;
        cfg_ch.data  <= msb_top;
        do @(posedge i_clk); while (cfg_ch.ready !== 1'b1);
        copy_display_msb_top = msb_top;
        cfg_ch.valid <= 1'b0;
    endtask

    // a write item; page and group get noise since the block ignores them
    function automatic t_stim write_item(input logic [9:0] addr, input logic [7:0] wbyte);
        return '{OP_WRITE, addr, wbyte, 3'($urandom), 4'($urandom), 1'b0, 8'h00, 8'h00};
    endfunction

    // a read item; address and byte get noise
    function automatic t_stim read_item(input logic [2:0] page, input logic [3:0] grp);
        return '{OP_READ, 10'($urandom), 8'($urandom), page, grp, 1'b0, 8'h00, 8'h00};
    endfunction

    // mostly: write a few rows of one block then read that block back
    task automatic run_random(input int n_items);
        int         sent;
        int         choice;
        int         k;
        logic [2:0] pg;
        logic [3:0] grp;
        sent = 0;
        while (sent < n_items) begin
            choice = $urandom_range(0, 19);
            if (choice < 15) begin
                pg  = 3'($urandom_range(0, 7));
                // group 0 is favoured so the position commands show up often
                grp = ($urandom_range(0, 3) == 0) ? 4'd0 : 4'($urandom_range(0, 15));
                k   = $urandom_range(1, 8);
                repeat (k)
                    send_item(write_item({pg, 3'($urandom_range(0, 7)), grp}, 8'($urandom)));
                send_item(read_item(pg, grp));
                sent += k + 1;
            end else if (choice < 17) begin
                send_item(write_item(10'($urandom), 8'($urandom)));
                sent++;
            end else if (choice < 19) begin
                send_item(read_item(3'($urandom), 4'($urandom)));
                sent++;
            end else begin
                // let everything drain before going on
                drain_results();
            end
        end
    endtask

    // receiver stalls: each mode holds for a random stretch
    always @(posedge i_clk) begin
        if (sink_mode_left == 0) begin
            sink_mode      = t_sink_mode'($urandom_range(0, 2));
            sink_mode_left = $urandom_range(20, 80);
        end
        sink_mode_left--;
        case (sink_mode)
            SINK_FREE: begin
                out_ch.ready <= 1'b1;
            end
            SINK_RANDOM: begin
                out_ch.ready <= ($urandom_range(0, 1) == 1);
            end
            default: begin
                out_ch.ready <= ($urandom_range(0, 3) == 0);
            end
        endcase
    end

    // every accepted byte is checked against the oldest one due
    always @(posedge i_clk) begin : result_check
        t_panel_byte got;
        t_panel_byte want;
        if (i_rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            got = '{out_ch.out_byte, out_ch.is_command, out_ch.last};
            if (panel_bytes_due.size() == 0) begin
                report_mismatch($sformatf("unexpected byte %h cmd %b last %b",
                                          got.out_byte, got.is_command, got.last));
            end else begin
                want = panel_bytes_due.pop_front();
                if (got !== want)
                    report_mismatch($sformatf("byte %h cmd %b last %b, wanted %h cmd %b last %b",
                                              got.out_byte, got.is_command, got.last,
                                              want.out_byte, want.is_command, want.last));
            end
        end
    end

    initial begin : stimulus
        // every input known from time zero, reset held low
        i_rst_n             = 1'b0;
        in_ch.valid         = 1'b0;
        in_ch.op            = OP_WRITE;
        in_ch.byte_address  = '0;
        in_ch.write_byte    = '0;
        in_ch.page          = '0;
        in_ch.column_group  = '0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.index        = CFG_FB_MSB_LEFT;
        cfg_ch.data         = 1'b0;
        out_ch.ready        = 1'b0;
        foreach (frame_copy[a])
            frame_copy[a] = 8'h00;
        copy_fb_msb_left     = 1'b0;
        copy_display_msb_top = 1'b0;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed rows at the reset orientation; the first waits out the clearing pass
        for (int i = 0; i < NUM_DIRECTED; i++)
            send_item(DIRECTED[i]);

        // random traffic under each orientation, both extremes included
        foreach (RANDOM_SETTINGS[s]) begin
            drain_results();
            write_settings(RANDOM_SETTINGS[s][1], RANDOM_SETTINGS[s][0]);
            run_random(RANDOM_PER_SETTING);
        end

        drain_results();
        if (mismatch_count == 0 && panel_bytes_due.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
